// ===== src/bmk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Banked mapper shared definitions
// Beat types, action and target codes, register pages, store geometry and
// the kanji bank lookup table.
// ----------------------------------------------------------------------------
package bmk_pkg;

   localparam int TILE_STORE_DEPTH = 2048;
   localparam int STORE_AW         = $clog2(TILE_STORE_DEPTH);
   localparam int HALF_DEPTH       = TILE_STORE_DEPTH / 2;
   localparam int HALF_AW          = $clog2(HALF_DEPTH);

   localparam logic [2:0] ACT_CPU_READ  = 3'd0;
   localparam logic [2:0] ACT_CPU_WRITE = 3'd1;
   localparam logic [2:0] ACT_VID_READ  = 3'd2;
   localparam logic [2:0] ACT_VID_WRITE = 3'd3;
   localparam logic [2:0] ACT_TICK      = 3'd4;

   localparam logic [2:0] TGT_NONE     = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM  = 3'd1;
   localparam logic [2:0] TGT_PRG_RAM  = 3'd2;
   localparam logic [2:0] TGT_CHR_ROM  = 3'd3;
   localparam logic [2:0] TGT_CHR_RAM  = 3'd4;
   localparam logic [2:0] TGT_CIRAM    = 3'd5;
   localparam logic [2:0] TGT_INTERNAL = 3'd6;

   localparam logic [7:0] PAGE_SAVE0     = 8'hd0;
   localparam logic [7:0] PAGE_SAVE1     = 8'hd1;
   localparam logic [7:0] PAGE_PRG0      = 8'hd2;
   localparam logic [7:0] PAGE_PRG1      = 8'hd3;
   localparam logic [7:0] PAGE_PRG2      = 8'hd4;
   localparam logic [7:0] PAGE_CHR       = 8'hd5;
   localparam logic [7:0] PAGE_RELOAD_LO = 8'hd6;
   localparam logic [7:0] PAGE_RELOAD_HI = 8'hd7;
   localparam logic [7:0] PAGE_IRQ_ACK   = 8'hd8;
   localparam logic [7:0] PAGE_IRQ_CTRL  = 8'hd9;
   localparam logic [7:0] PAGE_NT_CTRL   = 8'hda;
   localparam logic [7:0] PAGE_KANJI_Q   = 8'hdb;
   localparam logic [7:0] PAGE_KANJI_COL = 8'hdc;
   localparam logic [7:0] PAGE_KANJI_ROW = 8'hdd;

   localparam logic [7:0] KANJI_BANKS [4][8] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h40, 8'h10, 8'h28, 8'h00, 8'h18, 8'h30},
      '{8'h00, 8'h00, 8'h48, 8'h18, 8'h30, 8'h08, 8'h20, 8'h38},
      '{8'h00, 8'h00, 8'h80, 8'h20, 8'h38, 8'h10, 8'h28, 8'hb0}
   };

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [8:0]  dot_position;
   } req_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [19:0] mem_address;
      logic        mem_write;
      logic [7:0]  mem_data;
      logic [7:0]  read_data;
      logic        irq_level;
   } rsp_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_write_type;

   typedef struct packed {
      logic               en;
      logic [HALF_AW-1:0] addr;
      logic [7:0]         data;
   } ram_write_type;

endpackage
`default_nettype wire

// ===== src/banked_mapper_kanji_latch_irq_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Banked mapper with kanji lookup, IRQ counter and nametable store
// Translates CPU and video bus beats into target memory accesses or
// internally supplied bytes, one result beat per request beat.
// ----------------------------------------------------------------------------
// The block takes one request beat every clock cycle unless req_stall is high
// (while clearing, or while a held result is stalled by rsp_stall); the beat
// sits in an input register while the nametable store is read, and the
// decoded result is held in an output register. After reset the internal
// nametable store is swept to zero, with both store halves cleared in
// parallel; req_stall stays high for that time.
module banked_mapper_kanji_latch_irq_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bmk_pkg::req_type  req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bmk_pkg::rsp_type       rsp_item
);

   logic                            s1_vld_ff, s1_vld_in;
   bmk_pkg::req_type                s1_item_ff;
   logic                            rsp_vld_ff, rsp_vld_in;
   bmk_pkg::rsp_type                rsp_item_ff;
   logic                            clear_ff, clear_in;
   logic [bmk_pkg::HALF_AW-1:0]     clear_addr_ff, clear_addr_in;

   logic                            advance;
   logic                            accept;
   bmk_pkg::rsp_type                core_result;
   bmk_pkg::store_write_type        core_wr;
   bmk_pkg::ram_write_type          wr_lo;
   bmk_pkg::ram_write_type          wr_hi;
   logic [7:0]                      store_lo;
   logic [7:0]                      store_hi;

   assign advance   = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_vld_ff && !advance);
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept || (s1_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   assign clear_in      = clear_ff && (clear_addr_ff != {bmk_pkg::HALF_AW{1'b1}});
   assign clear_addr_in = clear_addr_ff + 1'b1;

   always_comb begin
      if (clear_ff) begin
         wr_lo.en   = 1'b1;
         wr_lo.addr = clear_addr_ff;
         wr_lo.data = 8'h00;
         wr_hi      = wr_lo;
      end else begin
         wr_lo.en   = core_wr.en && !core_wr.addr[bmk_pkg::STORE_AW-1];
         wr_lo.addr = core_wr.addr[bmk_pkg::HALF_AW-1:0];
         wr_lo.data = core_wr.data;
         wr_hi.en   = core_wr.en && core_wr.addr[bmk_pkg::STORE_AW-1];
         wr_hi.addr = core_wr.addr[bmk_pkg::HALF_AW-1:0];
         wr_hi.data = core_wr.data;
      end
   end

   bmk_tile_ram u_ram_lo (
      .clock   (clock),
      .wr      (wr_lo),
      .rd_en   (accept),
      .rd_addr (req_item.address[bmk_pkg::HALF_AW-1:0]),
      .rd_data (store_lo)
   );

   bmk_tile_ram u_ram_hi (
      .clock   (clock),
      .wr      (wr_hi),
      .rd_en   (accept),
      .rd_addr (req_item.address[bmk_pkg::HALF_AW-1:0]),
      .rd_data (store_hi)
   );

   bmk_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (s1_item_ff),
      .store_lo (store_lo),
      .store_hi (store_hi),
      .result   (core_result),
      .store_wr (core_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         clear_ff   <= clear_in;
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// ===== src/bmk_tile_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nametable store half
// One write port and one registered read port; a read at the address being
// written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module bmk_tile_ram (
   input  wire logic                           clock,
   input  wire bmk_pkg::ram_write_type         wr,
   input  wire logic                           rd_en,
   input  wire logic [bmk_pkg::HALF_AW-1:0]    rd_addr,
   output logic [7:0]                          rd_data
);

   logic [7:0] mem [bmk_pkg::HALF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/bmk_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mapper decode and register file
// Holds the bank, IRQ, nametable, kanji and fetch latch registers and decodes
// one beat into a result and an optional store write.
// ----------------------------------------------------------------------------
module bmk_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire bmk_pkg::req_type         item,
   input  wire logic [7:0]               store_lo,
   input  wire logic [7:0]               store_hi,
   output bmk_pkg::rsp_type              result,
   output bmk_pkg::store_write_type      store_wr
);

   logic [1:0]      save_bank_ff, save_bank_in;
   logic [1:0]      save_int_ff, save_int_in;
   logic [2:0][5:0] prg_bank_ff, prg_bank_in;
   logic [2:0]      prg_ext_ff, prg_ext_in;
   logic            chr_low_ff, chr_low_in;
   logic [15:0]     irq_count_ff, irq_count_in;
   logic [15:0]     irq_reload_ff, irq_reload_in;
   logic            irq_repeat_ff, irq_repeat_in;
   logic            irq_enable_ff, irq_enable_in;
   logic            irq_out_ff, irq_out_in;
   logic            nt_sel_ff, nt_sel_in;
   logic            mirror_h_ff, mirror_h_in;
   logic [1:0]      kanji_quad_ff, kanji_quad_in;
   logic            kanji_alt_ff, kanji_alt_in;
   logic [6:0]      kanji_col_ff, kanji_col_in;
   logic [6:0]      kanji_row_ff, kanji_row_in;
   logic [7:0]      latch_byte_ff, latch_byte_in;
   logic [1:0]      latch_left_ff, latch_left_in;

   logic [15:0] a;
   logic [7:0]  d;
   logic [13:0] v;
   logic [7:0]  kd;
   logic [7:0]  kanji_lo;
   logic [7:0]  kanji_hi;
   logic [5:0]  win_bank;
   logic        win_ext;
   logic [19:0] prg_addr;
   logic [13:0] save_addr;
   logic        half_sel;
   logic [10:0] nt_idx;
   logic [7:0]  stored;
   logic        dot_hit;

   assign a = item.address;
   assign d = item.write_data;
   assign v = item.address[13:0];

   always_comb begin
      kd       = bmk_pkg::KANJI_BANKS[kanji_col_ff[6:5]][kanji_row_ff[6:4]];
      kanji_lo = {kanji_row_ff[0], kanji_col_ff[4:0], kanji_quad_ff};
      kanji_hi = {kanji_alt_ff, 1'b1, 6'b0} | {2'b0, kd[5:0]} | {5'b0, kanji_row_ff[3:1]};
      if (kd[6]) begin
         kanji_hi[2] = 1'b0;
      end else if (kd[7]) begin
         kanji_hi[2] = 1'b1;
      end
   end

   always_comb begin
      case (a[14:13])
         2'd0: begin
            win_bank = prg_bank_ff[0];
            win_ext  = prg_ext_ff[0];
         end
         2'd1: begin
            win_bank = prg_bank_ff[1];
            win_ext  = prg_ext_ff[1];
         end
         2'd2: begin
            win_bank = prg_bank_ff[2];
            win_ext  = prg_ext_ff[2];
         end
         default: begin
            win_bank = 6'h3f;
            win_ext  = 1'b1;
         end
      endcase
      prg_addr  = ({19'd0, win_ext} << 17) + {1'b0, win_bank, a[12:0]};
      save_addr = {~save_int_ff[a[12]], save_bank_ff[a[12]], a[11:0]};
      half_sel  = mirror_h_ff ? v[11] : v[10];
      nt_idx    = {half_sel, v[9:0]};
      stored    = half_sel ? store_hi : store_lo;
      dot_hit   = ((item.dot_position >= 9'd1 && item.dot_position <= 9'd256) ||
                   (item.dot_position >= 9'd321 && item.dot_position <= 9'd336)) &&
                  (item.dot_position[2:0] == 3'd1);
   end

   always_comb begin
      save_bank_in  = save_bank_ff;
      save_int_in   = save_int_ff;
      prg_bank_in   = prg_bank_ff;
      prg_ext_in    = prg_ext_ff;
      chr_low_in    = chr_low_ff;
      irq_count_in  = irq_count_ff;
      irq_reload_in = irq_reload_ff;
      irq_repeat_in = irq_repeat_ff;
      irq_enable_in = irq_enable_ff;
      irq_out_in    = irq_out_ff;
      nt_sel_in     = nt_sel_ff;
      mirror_h_in   = mirror_h_ff;
      kanji_quad_in = kanji_quad_ff;
      kanji_alt_in  = kanji_alt_ff;
      kanji_col_in  = kanji_col_ff;
      kanji_row_in  = kanji_row_ff;
      latch_byte_in = latch_byte_ff;
      latch_left_in = latch_left_ff;
      result        = '0;
      store_wr      = '0;

      case (item.action)
         bmk_pkg::ACT_CPU_READ: begin
            if (a[15:8] == bmk_pkg::PAGE_KANJI_COL) begin
               result.target    = bmk_pkg::TGT_INTERNAL;
               result.read_data = kanji_lo;
            end else if (a[15:8] == bmk_pkg::PAGE_KANJI_ROW) begin
               result.target    = bmk_pkg::TGT_INTERNAL;
               result.read_data = kanji_hi;
            end else if (a[15]) begin
               result.target      = bmk_pkg::TGT_PRG_ROM;
               result.mem_address = prg_addr;
            end else if (a[14:13] == 2'b11) begin
               result.target      = bmk_pkg::TGT_PRG_RAM;
               result.mem_address = {6'd0, save_addr};
            end
         end
         bmk_pkg::ACT_CPU_WRITE: begin
            if (a[15:13] == 3'b011) begin
               result.target      = bmk_pkg::TGT_PRG_RAM;
               result.mem_address = {6'd0, save_addr};
               result.mem_write   = 1'b1;
               result.mem_data    = d;
            end else begin
               case (a[15:8])
                  bmk_pkg::PAGE_SAVE0: begin
                     save_bank_in[0] = d[0];
                     save_int_in[0]  = d[3];
                  end
                  bmk_pkg::PAGE_SAVE1: begin
                     save_bank_in[1] = d[0];
                     save_int_in[1]  = d[3];
                  end
                  bmk_pkg::PAGE_PRG0: begin
                     prg_ext_in[0]  = d[6];
                     prg_bank_in[0] = d[6] ? d[5:0] : {2'b0, d[3:0]};
                  end
                  bmk_pkg::PAGE_PRG1: begin
                     prg_ext_in[1]  = d[6];
                     prg_bank_in[1] = d[6] ? d[5:0] : {2'b0, d[3:0]};
                  end
                  bmk_pkg::PAGE_PRG2: begin
                     prg_ext_in[2]  = d[6];
                     prg_bank_in[2] = d[6] ? d[5:0] : {2'b0, d[3:0]};
                  end
                  bmk_pkg::PAGE_CHR: chr_low_in = d[0];
                  bmk_pkg::PAGE_RELOAD_LO: irq_reload_in = {irq_reload_ff[15:8], d};
                  bmk_pkg::PAGE_RELOAD_HI: irq_reload_in = {d, irq_reload_ff[7:0]};
                  bmk_pkg::PAGE_IRQ_ACK: begin
                     irq_enable_in = irq_repeat_ff;
                     irq_out_in    = 1'b0;
                  end
                  bmk_pkg::PAGE_IRQ_CTRL: begin
                     irq_repeat_in = d[0];
                     irq_enable_in = d[1];
                     irq_count_in  = irq_reload_ff;
                     irq_out_in    = 1'b0;
                  end
                  bmk_pkg::PAGE_NT_CTRL: begin
                     nt_sel_in   = d[0];
                     mirror_h_in = d[1];
                  end
                  bmk_pkg::PAGE_KANJI_Q: begin
                     kanji_quad_in = d[1:0];
                     kanji_alt_in  = d[2];
                  end
                  bmk_pkg::PAGE_KANJI_COL: kanji_col_in = d[6:0];
                  bmk_pkg::PAGE_KANJI_ROW: kanji_row_in = d[6:0];
                  default: ;
               endcase
            end
         end
         bmk_pkg::ACT_VID_READ: begin
            if (!v[13] && (latch_left_ff != 2'd0)) begin
               latch_left_in = latch_left_ff - 2'd1;
               if ((latch_byte_ff[7:6] == 2'b11) && v[3]) begin
                  result.target    = bmk_pkg::TGT_INTERNAL;
                  result.read_data = 8'hff;
               end else if (latch_byte_ff[6]) begin
                  result.target      = bmk_pkg::TGT_CHR_ROM;
                  result.mem_address = {2'd0, latch_byte_ff[5:0], v[11:0]};
               end else begin
                  result.target      = bmk_pkg::TGT_CHR_RAM;
                  result.mem_address = {7'd0, latch_byte_ff[0], v[11:0]};
               end
            end else if (v[13:12] == 2'b00) begin
               result.target      = bmk_pkg::TGT_CHR_RAM;
               result.mem_address = {7'd0, chr_low_ff, v[11:0]};
            end else if (v[13:12] == 2'b01) begin
               result.target      = bmk_pkg::TGT_CHR_RAM;
               result.mem_address = {7'd0, 1'b1, v[11:0]};
            end else if (v[13:12] == 2'b10) begin
               if (dot_hit) begin
                  latch_byte_in = stored;
                  latch_left_in = 2'd2;
               end
               if (nt_sel_ff) begin
                  result.target    = bmk_pkg::TGT_INTERNAL;
                  result.read_data = stored;
               end else begin
                  result.target      = bmk_pkg::TGT_CIRAM;
                  result.mem_address = {9'd0, nt_idx};
               end
            end
         end
         bmk_pkg::ACT_VID_WRITE: begin
            if (v[13:12] == 2'b00) begin
               result.target      = bmk_pkg::TGT_CHR_RAM;
               result.mem_address = {7'd0, chr_low_ff, v[11:0]};
               result.mem_write   = 1'b1;
               result.mem_data    = d;
            end else if (v[13:12] == 2'b01) begin
               result.target      = bmk_pkg::TGT_CHR_RAM;
               result.mem_address = {7'd0, 1'b1, v[11:0]};
               result.mem_write   = 1'b1;
               result.mem_data    = d;
            end else if (v[13:12] == 2'b10) begin
               result.target      = nt_sel_ff ? bmk_pkg::TGT_INTERNAL : bmk_pkg::TGT_CIRAM;
               result.mem_address = {9'd0, nt_idx};
               result.mem_write   = 1'b1;
               result.mem_data    = d;
               store_wr.en        = nt_sel_ff;
               store_wr.addr      = nt_idx;
               store_wr.data      = d;
            end
         end
         bmk_pkg::ACT_TICK: begin
            if (irq_enable_ff) begin
               if (irq_count_ff == 16'hffff) begin
                  irq_count_in = irq_reload_ff;
                  irq_out_in   = 1'b1;
               end else begin
                  irq_count_in = irq_count_ff + 16'd1;
               end
            end
         end
         default: ;
      endcase

      result.irq_level = irq_out_in;
      store_wr.en      = store_wr.en & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_bank_ff  <= '0;
         save_int_ff   <= '0;
         prg_bank_ff   <= '0;
         prg_ext_ff    <= '0;
         chr_low_ff    <= 1'b0;
         irq_count_ff  <= '0;
         irq_reload_ff <= '0;
         irq_repeat_ff <= 1'b0;
         irq_enable_ff <= 1'b0;
         irq_out_ff    <= 1'b0;
         nt_sel_ff     <= 1'b0;
         mirror_h_ff   <= 1'b0;
         kanji_quad_ff <= '0;
         kanji_alt_ff  <= 1'b0;
         kanji_col_ff  <= '0;
         kanji_row_ff  <= '0;
         latch_byte_ff <= '0;
         latch_left_ff <= '0;
      end else if (step) begin
         save_bank_ff  <= save_bank_in;
         save_int_ff   <= save_int_in;
         prg_bank_ff   <= prg_bank_in;
         prg_ext_ff    <= prg_ext_in;
         chr_low_ff    <= chr_low_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
         irq_repeat_ff <= irq_repeat_in;
         irq_enable_ff <= irq_enable_in;
         irq_out_ff    <= irq_out_in;
         nt_sel_ff     <= nt_sel_in;
         mirror_h_ff   <= mirror_h_in;
         kanji_quad_ff <= kanji_quad_in;
         kanji_alt_ff  <= kanji_alt_in;
         kanji_col_ff  <= kanji_col_in;
         kanji_row_ff  <= kanji_row_in;
         latch_byte_ff <= latch_byte_in;
         latch_left_ff <= latch_left_in;
      end
   end

endmodule
`default_nettype wire
